// ===== rtl/slps_pkg.sv =====
// ----------------------------------------------------------------------------
// slps_pkg: shared types, constants and step functions
// Holds the fixed-point light table, the pipeline payload types and the
// single-step divide and square root helpers used by the pixel shader.
// ----------------------------------------------------------------------------
package slps_pkg;

  localparam int MAX_SIZE  = 4096;
  localparam int FRAC_BITS = 16;

  localparam int SIZE_W  = 13;
  localparam int PIX_W   = 12;
  localparam int NUM_W   = 30;   // ((2p+1) << 16) + size/2
  localparam int REM_W   = 12;   // division remainder, below size
  localparam int COORD_W = 18;   // signed u, v in Q16
  localparam int SQ_W    = 33;   // radicand, at most 2^32
  localparam int ROOT_W  = 17;   // z, at most 2^16
  localparam int PROD_W  = 36;
  localparam int DOT_W   = 38;
  localparam int DQ_W    = 17;

  localparam int DIV_STEPS_PER_STAGE  = 5;
  localparam int DIV_STAGES           = 6;
  localparam int SQRT_STEPS_PER_STAGE = 3;
  localparam int SQRT_STAGES          = 6;

  localparam logic signed [COORD_W-1:0] ONE_Q = 18'sd65536;
  localparam logic [33:0] ONE_SQ = 34'h1_0000_0000;

  // Unit light directions in Q16: rows red, green, blue; columns x, y, z.
  localparam logic signed [COORD_W-1:0] LIGHT [3][3] = '{
    '{-18'sd32655, -18'sd16327, 18'sd54425},
    '{ 18'sd32655, -18'sd16327, 18'sd54425},
    '{ 18'sd0,      18'sd37582, 18'sd53689}
  };

  typedef struct packed {
    logic              kill;
    logic [SIZE_W-1:0] size;
    logic [NUM_W-1:0]  nx;    // dividend shifting out, quotient shifting in
    logic [NUM_W-1:0]  ny;
    logic [REM_W-1:0]  rx;
    logic [REM_W-1:0]  ry;
  } div_t;

  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
  } sqrt_acc_t;

  typedef struct packed {
    logic                        ok;
    logic signed [COORD_W-1:0]   u;
    logic signed [COORD_W-1:0]   v;
    sqrt_acc_t                   acc;
  } sqrt_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] num;
  } div_acc_t;

  // One restoring division step.
  function automatic div_acc_t div_step(div_acc_t a, logic [SIZE_W-1:0] size);
    div_acc_t          res;
    logic [REM_W:0]    r;
    r = {a.rem, a.num[NUM_W-1]};
    res.num = {a.num[NUM_W-2:0], 1'b0};
    res.rem = r[REM_W-1:0];
    if (r >= size) begin
      r = r - size;
      res.rem = r[REM_W-1:0];
      res.num[0] = 1'b1;
    end
    return res;
  endfunction

  // One square root digit: try setting root bit i.
  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t a, int i);
    sqrt_acc_t   res;
    logic [34:0] t;
    res = a;
    t = ({18'd0, a.root} << (i + 1)) + (35'd1 << (2 * i));
    if ({2'b00, a.rem} >= t) begin
      res.rem  = a.rem - t[SQ_W-1:0];
      res.root = a.root | (ROOT_W'(1) << i);
    end
    return res;
  endfunction

endpackage

// ===== rtl/sphere_lambert_pixel_shader.sv =====
// ----------------------------------------------------------------------------
// sphere_lambert_pixel_shader: Lambert-shaded unit sphere pixel generator
// Maps a pixel of a square image to an RGBA word of a sphere lit by three
// fixed lights, in Q16 fixed point, one pixel per clock unless the output stalls.
// ----------------------------------------------------------------------------
// One pixel word in, one RGBA word out, at one word per clock while the output
// is not stalled. The pipeline is 20 register stages: input capture, six stages
// of a restoring divider (five quotient bits per stage) that turn the pixel
// centre into Q16 coordinates, the centering to u and v, the squares of u and
// v, the radicand 1 - r2 with the disc test, six stages of a digit-by-digit
// square root (up to three root bits per stage) for z, the light products, their
// sums, the rounding and the final scale to 0..255, which is the output
// register. Each stage holds only while it is full and the stage after it is
// blocked, so bubbles close up and new pixels keep entering while a finished
// word waits.
// image_size (capped at 4096) may be changed only with the pipeline empty.
// Pixels outside the disc or outside the image, and any pixel with size zero,
// give an all-zero word.
module sphere_lambert_pixel_shader (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,      // image_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,     // [11:0] pixel_x, [23:12] pixel_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata      // [7:0] red, [15:8] green, [23:16] blue,
                                        // [31:24] alpha
);

  localparam int NST     = 20;
  localparam int ST_DIV0 = 0;
  localparam int ST_UV   = ST_DIV0 + slps_pkg::DIV_STAGES + 1;
  localparam int ST_SQR  = ST_UV + 1;
  localparam int ST_SQ0  = ST_SQR + 1;
  localparam int ST_MUL  = ST_SQ0 + slps_pkg::SQRT_STAGES + 1;
  localparam int ST_SUM  = ST_MUL + 1;
  localparam int ST_DQ   = ST_SUM + 1;
  localparam int ST_OUT  = ST_DQ + 1;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  logic [slps_pkg::SIZE_W-1:0] image_size;

  // Hold a stage only while it is full and the next one cannot take it.
  always_comb begin
    en[NST-1] = !vld[NST-1] || m_axis_tready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      image_size <= 13'd256;
    end else begin
      if (cfg_wr_en) begin
        image_size <= cfg_wr_data;
      end
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input capture: cap the size, flag pixels off the image, build dividends.
  // --------------------------------------------------------------------------
  slps_pkg::div_t dv [slps_pkg::DIV_STAGES+1];

  logic [slps_pkg::PIX_W-1:0]  px, py;
  logic [slps_pkg::SIZE_W-1:0] size_eff;

  assign px = s_axis_tdata[11:0];
  assign py = s_axis_tdata[23:12];
  assign size_eff = (image_size > slps_pkg::SIZE_W'(slps_pkg::MAX_SIZE)) ?
                    slps_pkg::SIZE_W'(slps_pkg::MAX_SIZE) : image_size;

  always_ff @(posedge clk) begin
    if (en[ST_DIV0]) begin
      dv[0].kill <= (size_eff == '0) || ({1'b0, px} >= size_eff) ||
                    ({1'b0, py} >= size_eff);
      dv[0].size <= size_eff;
      dv[0].nx   <= {1'b0, px, 1'b1, 16'd0} + {18'd0, size_eff[12:1]};
      dv[0].ny   <= {1'b0, py, 1'b1, 16'd0} + {18'd0, size_eff[12:1]};
      dv[0].rx   <= '0;
      dv[0].ry   <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: five quotient bits of each coordinate per stage.
  // --------------------------------------------------------------------------
  for (genvar k = 1; k <= slps_pkg::DIV_STAGES; k++) begin : g_div
    slps_pkg::div_t nxt;
    always_comb begin
      slps_pkg::div_acc_t ax, ay;
      ax = '{rem: dv[k-1].rx, num: dv[k-1].nx};
      ay = '{rem: dv[k-1].ry, num: dv[k-1].ny};
      for (int j = 0; j < slps_pkg::DIV_STEPS_PER_STAGE; j++) begin
        ax = slps_pkg::div_step(ax, dv[k-1].size);
        ay = slps_pkg::div_step(ay, dv[k-1].size);
      end
      nxt      = dv[k-1];
      nxt.nx   = ax.num;
      nxt.rx   = ax.rem;
      nxt.ny   = ay.num;
      nxt.ry   = ay.rem;
    end
    always_ff @(posedge clk) begin
      if (en[ST_DIV0 + k]) begin
        dv[k] <= nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Centre the coordinates, then square and sum them.
  // --------------------------------------------------------------------------
  logic                                  ok_uv, ok_sqr;
  logic signed [slps_pkg::COORD_W-1:0]   u_uv, v_uv, u_sqr, v_sqr;
  logic signed [slps_pkg::PROD_W-1:0]    uu, vv;
  logic [33:0]                           r2;

  always_ff @(posedge clk) begin
    if (en[ST_UV]) begin
      ok_uv <= !dv[slps_pkg::DIV_STAGES].kill;
      u_uv  <= $signed({1'b0, dv[slps_pkg::DIV_STAGES].nx[16:0]}) - slps_pkg::ONE_Q;
      v_uv  <= slps_pkg::ONE_Q - $signed({1'b0, dv[slps_pkg::DIV_STAGES].ny[16:0]});
    end
    if (en[ST_SQR]) begin
      ok_sqr <= ok_uv;
      u_sqr  <= u_uv;
      v_sqr  <= v_uv;
      uu     <= u_uv * u_uv;
      vv     <= v_uv * v_uv;
    end
  end

  assign r2 = uu[33:0] + vv[33:0];

  // --------------------------------------------------------------------------
  // Square root of 1 - r2: up to three root bits per stage.
  // --------------------------------------------------------------------------
  slps_pkg::sqrt_t sq [slps_pkg::SQRT_STAGES+1];

  always_ff @(posedge clk) begin
    if (en[ST_SQ0]) begin
      sq[0].ok       <= ok_sqr && (r2 <= slps_pkg::ONE_SQ);
      sq[0].u        <= u_sqr;
      sq[0].v        <= v_sqr;
      sq[0].acc.rem  <= (r2 <= slps_pkg::ONE_SQ) ? 33'(slps_pkg::ONE_SQ - r2) : '0;
      sq[0].acc.root <= '0;
    end
  end

  for (genvar q = 1; q <= slps_pkg::SQRT_STAGES; q++) begin : g_sqrt
    slps_pkg::sqrt_t nxt;
    always_comb begin
      nxt = sq[q-1];
      for (int j = 0; j < slps_pkg::SQRT_STEPS_PER_STAGE; j++) begin
        if (16 - slps_pkg::SQRT_STEPS_PER_STAGE * (q - 1) - j >= 0) begin
          nxt.acc = slps_pkg::sqrt_step(nxt.acc,
                      16 - slps_pkg::SQRT_STEPS_PER_STAGE * (q - 1) - j);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en[ST_SQ0 + q]) begin
        sq[q] <= nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Light products, dot products, rounding to Q16, scale to 8 bits.
  // --------------------------------------------------------------------------
  logic signed [slps_pkg::COORD_W-1:0] z_s;
  logic signed [slps_pkg::PROD_W-1:0]  prod [3][3];
  logic signed [slps_pkg::DOT_W-1:0]   dot [3];
  logic [slps_pkg::DQ_W-1:0]           dq [3];
  logic                                ok_mul, ok_sum, ok_dq;
  logic [7:0]                          ch [3];

  // Sign-extend a product to the dot product width.
  function automatic logic signed [slps_pkg::DOT_W-1:0] DOT_W_EXT(
      logic signed [slps_pkg::PROD_W-1:0] p);
    return {{(slps_pkg::DOT_W - slps_pkg::PROD_W){p[slps_pkg::PROD_W-1]}}, p};
  endfunction

  // Round a positive Q32 dot product to Q16, clamp at one, drop negatives.
  function automatic logic [slps_pkg::DQ_W-1:0] dq_round(
      logic signed [slps_pkg::DOT_W-1:0] d);
    logic signed [slps_pkg::DOT_W-1:0] r;
    r = (d + 38'sd32768) >>> 16;
    if (d <= 0) return '0;
    if (r > 38'sd65536) return 17'd65536;
    return r[slps_pkg::DQ_W-1:0];
  endfunction

  // channel = (dq * 255 + half) >> 16, saturated at 255.
  function automatic logic [7:0] scale8(logic [slps_pkg::DQ_W-1:0] d);
    logic [25:0] t;
    t = ({1'b0, d, 8'd0} - {9'd0, d}) + 26'd32768;
    if (t[25:16] > 10'd255) return 8'hFF;
    return t[23:16];
  endfunction

  assign z_s = $signed({1'b0, sq[slps_pkg::SQRT_STAGES].acc.root});

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      ok_mul <= sq[slps_pkg::SQRT_STAGES].ok;
      for (int c = 0; c < 3; c++) begin
        prod[c][0] <= sq[slps_pkg::SQRT_STAGES].u * slps_pkg::LIGHT[c][0];
        prod[c][1] <= sq[slps_pkg::SQRT_STAGES].v * slps_pkg::LIGHT[c][1];
        prod[c][2] <= z_s * slps_pkg::LIGHT[c][2];
      end
    end
    if (en[ST_SUM]) begin
      ok_sum <= ok_mul;
      for (int c = 0; c < 3; c++) begin
        dot[c] <= DOT_W_EXT(prod[c][0]) + DOT_W_EXT(prod[c][1]) + DOT_W_EXT(prod[c][2]);
      end
    end
    if (en[ST_DQ]) begin
      ok_dq <= ok_sum;
      for (int c = 0; c < 3; c++) begin
        dq[c] <= dq_round(dot[c]);
      end
    end
    if (en[ST_OUT]) begin
      m_axis_tdata <= ok_dq ? {8'hFF, scale8(dq[2]), scale8(dq[1]), scale8(dq[0])}
                            : 32'd0;
    end
  end

  assign ch[0] = m_axis_tdata[7:0];
  assign ch[1] = m_axis_tdata[15:8];
  assign ch[2] = m_axis_tdata[23:16];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_zero_outside: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[31:24] == 8'd0) |->
      (ch[0] == 8'd0) && (ch[1] == 8'd0) && (ch[2] == 8'd0))
    else $error("nonzero color with zero alpha");

  a_alpha_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[31:24] == 8'd0) || (m_axis_tdata[31:24] == 8'hFF))
    else $error("alpha neither clear nor opaque");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !vld[NST-1] |-> s_axis_tready)
    else $error("input blocked with empty output register");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vld[0])
    else $error("accepted word lost at input stage");

endmodule
